// ===== hw/rtl/wvf_pkg.sv =====
package wvf_pkg;

  localparam int unsigned WAYPOINT_DEPTH_DEF = 64;
  localparam logic [15:0] PAUSE_TICKS_RST    = 16'd50;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_POSE   = 2'd2;

  localparam logic signed [21:0] PI_Q16     = 22'sd205887;
  localparam logic signed [21:0] TWO_PI_Q16 = 22'sd411775;
  localparam logic signed [32:0] VZ_MAX     = 33'sd19661;
  localparam logic [31:0]        TWO_M      = 32'd131072;
  localparam logic [31:0]        HALF_M     = 32'd32768;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [15:0] yaw_rate;
    logic               active;
    logic [6:0]         target_now;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DIV,
    ST_CNORM,
    ST_CORD,
    ST_FIN
  } state_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/waypoint_velocity_follower.sv =====
// Waypoint velocity follower. Clear and append items fill a waypoint table
// (appends to a full table are dropped); each pose item yields one velocity
// command on out_item, marked by a one-cycle out_valid strobe that cannot be
// stalled. Clear and append items, and a pose item during a pause or after
// the last waypoint, are taken in idle without raising busy. A moving pose
// item runs the difference, the two squares and the square root, then the
// divider when the speed is capped, then a normalize and 16 CORDIC steps
// for the heading when dy is nonzero; its result strobes in the cycle after
// busy falls. The bit-serial square root and the one-bit-per-cycle divider
// set most of that work. busy is high while a pose item is worked.
module waypoint_velocity_follower
  import wvf_pkg::*;
#(
  parameter int unsigned WAYPOINT_DEPTH = WAYPOINT_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = $clog2(WAYPOINT_DEPTH + 1);
  localparam int unsigned AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;

  state_t state_r, state_nxt;

  logic [95:0]   mem [WAYPOINT_DEPTH];
  logic [95:0]   rd_r;

  logic [CW-1:0] point_count_r;
  logic [CW-1:0] target_index_r;
  logic [15:0]   pause_left_r;
  logic [15:0]   pause_ticks_r;

  in_item_t      inp_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [63:0]   sq_r, rad_r;
  logic [35:0]   rem_r;
  logic [31:0]   root_r;
  logic [4:0]    cnt_r;
  logic [33:0]   rx_r, ry_r;
  logic [15:0]   qx_r, qy_r;
  logic [32:0]   cx_r, cy_r;
  logic signed [33:0] x_r, y_r;
  logic signed [19:0] z_r;

  out_item_t     out_r;
  logic          out_valid_r;

  logic accept, pose_run;
  logic [32:0] ax, ay;
  logic far;
  logic [30:0] sax, say, mul_in;
  logic [61:0] prod;
  logic [35:0] rem_sh, trial;
  logic sq_ge;
  logic use_div, div_go, cord_need, need_right, need_left;
  logic [33:0] rx_sub, ry_sub;
  logic signed [33:0] xs, ys;
  logic [31:0] mx, my;
  logic signed [31:0] vx, vy, vz;
  logic signed [21:0] a_q, dir_q, err_q, errw_q;
  logic signed [18:0] yr19;
  logic signed [15:0] yr;
  logic arrive;
  logic [31:0] tidx_ext;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign pose_run  = accept && (in_item.func == FUNC_POSE) && (pause_left_r == 16'd0)
                     && (target_index_r < point_count_r);

  assign ax   = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ay   = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign far  = ax[32] | ax[31] | ay[32] | ay[31];
  assign sax  = far ? ax[32:2] : ax[30:0];
  assign say  = far ? ay[32:2] : ay[30:0];
  assign mul_in = (state_r == ST_SQX) ? sax : say;
  assign prod = mul_in * mul_in;

  assign rem_sh = {rem_r[33:0], rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  assign use_div   = far || (root_r > TWO_M);
  // last root bit lands at the final square root edge
  assign div_go    = far || ({root_r[30:0], sq_ge} > TWO_M);
  assign cord_need = (dy_r != 33'sd0);
  assign need_right = (cx_r[32:30] != 3'd0) || (cy_r[32:30] != 3'd0);
  assign need_left  = !cx_r[29] && !cy_r[29];

  assign rx_sub = rx_r - {2'b00, root_r};
  assign ry_sub = ry_r - {2'b00, root_r};
  assign xs = x_r >>> cnt_r[3:0];
  assign ys = y_r >>> cnt_r[3:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (pose_run) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == 5'd31) begin
          if (div_go) state_nxt = ST_DIV;
          else if (cord_need) state_nxt = ST_CNORM;
          else state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (cnt_r == 5'd15) state_nxt = cord_need ? ST_CNORM : ST_FIN;
      end
      ST_CNORM: if (!need_right && !need_left) state_nxt = ST_CORD;
      ST_CORD:  if (cnt_r == 5'd15) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // waypoint store
  always_ff @(posedge clk) begin
    if (accept && in_item.func == FUNC_APPEND && point_count_r < CW'(WAYPOINT_DEPTH))
      mem[point_count_r[AW-1:0]] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
    rd_r <= mem[target_index_r[AW-1:0]];
  end

  // result fields
  always_comb begin
    mx = use_div ? {16'd0, qx_r} : {3'd0, sax[30:2]};
    my = use_div ? {16'd0, qy_r} : {3'd0, say[30:2]};
    vx = (dx_r > 33'sd0) ? $signed(mx) : -$signed(mx);
    vy = (dy_r > 33'sd0) ? $signed(my) : -$signed(my);
    if (dz_r > VZ_MAX) vz = 32'(VZ_MAX);
    else if (dz_r < -VZ_MAX) vz = 32'(-VZ_MAX);
    else vz = 32'(dz_r);
    a_q = dx_r[32] ? (PI_Q16 - 22'(z_r)) : 22'(z_r);
    if (dy_r == 33'sd0) dir_q = (dx_r > 33'sd0) ? 22'sd0 : -PI_Q16;
    else dir_q = (dy_r > 33'sd0) ? a_q : -a_q;
    err_q = dir_q - (22'(inp_r.heading) <<< 3);
    if (err_q > PI_Q16) errw_q = err_q - TWO_PI_Q16;
    else if (err_q < -PI_Q16) errw_q = err_q + TWO_PI_Q16;
    else errw_q = err_q;
    yr19 = 19'((errw_q + 22'sd4) >>> 3);
    if (yr19 > 19'sd32767) yr = 16'sh7fff;
    else if (yr19 < -19'sd32768) yr = 16'sh8000;
    else yr = 16'(yr19);
    if (dx_r == 33'sd0 && dy_r == 33'sd0) yr = 16'sd0;
    arrive = !far && (root_r < HALF_M);
  end

  assign tidx_ext = 32'(target_index_r);

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) inp_r <= in_item;
        if (accept && in_item.func == FUNC_CLEAR) begin
          point_count_r  <= '0;
          target_index_r <= '0;
        end
        if (accept && in_item.func == FUNC_APPEND && point_count_r < CW'(WAYPOINT_DEPTH))
          point_count_r <= point_count_r + 1'b1;
        if (accept && in_item.func == FUNC_POSE && !pose_run) begin
          out_valid_r       <= 1'b1;
          out_r.vel_x       <= '0;
          out_r.vel_y       <= '0;
          out_r.vel_z       <= '0;
          out_r.yaw_rate    <= '0;
          out_r.active      <= (pause_left_r != 16'd0);
          out_r.target_now  <= tidx_ext[6:0];
          if (pause_left_r != 16'd0) pause_left_r <= pause_left_r - 16'd1;
        end
      end
      ST_DIFF: begin
        dx_r <= $signed({rd_r[95], rd_r[95:64]}) - $signed({inp_r.pos_x[31], inp_r.pos_x});
        dy_r <= $signed({rd_r[63], rd_r[63:32]}) - $signed({inp_r.pos_y[31], inp_r.pos_y});
        dz_r <= $signed({rd_r[31], rd_r[31:0]}) - $signed({inp_r.pos_z[31], inp_r.pos_z});
      end
      ST_SQX: begin
        sq_r <= {2'b00, prod};
        cx_r <= ax;
        cy_r <= ay;
      end
      ST_SQY: begin
        rad_r  <= sq_r + {2'b00, prod};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      ST_SQRT: begin
        rem_r  <= sq_ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[30:0], sq_ge};
        rad_r  <= {rad_r[61:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
        rx_r   <= {3'd0, sax};
        ry_r   <= {3'd0, say};
        qx_r   <= '0;
        qy_r   <= '0;
      end
      ST_DIV: begin
        rx_r  <= {(rx_r >= {2'b00, root_r}) ? rx_sub[32:0] : rx_r[32:0], 1'b0};
        ry_r  <= {(ry_r >= {2'b00, root_r}) ? ry_sub[32:0] : ry_r[32:0], 1'b0};
        qx_r  <= {qx_r[14:0], rx_r >= {2'b00, root_r}};
        qy_r  <= {qy_r[14:0], ry_r >= {2'b00, root_r}};
        cnt_r <= (cnt_r == 5'd15) ? 5'd0 : cnt_r + 5'd1;
      end
      ST_CNORM: begin
        if (need_right) begin
          cx_r <= cx_r >> 1;
          cy_r <= cy_r >> 1;
        end else if (need_left) begin
          cx_r <= cx_r << 1;
          cy_r <= cy_r << 1;
        end else begin
          x_r   <= $signed({1'b0, cx_r});
          y_r   <= $signed({1'b0, cy_r});
          z_r   <= '0;
          cnt_r <= '0;
        end
      end
      ST_CORD: begin
        if (y_r > 34'sd0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_q16(cnt_r[3:0]);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_q16(cnt_r[3:0]);
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_FIN: begin
        out_valid_r    <= 1'b1;
        out_r.vel_x    <= vx;
        out_r.vel_y    <= vy;
        out_r.vel_z    <= vz;
        out_r.yaw_rate <= yr;
        out_r.active   <= 1'b1;
        if (arrive) begin
          target_index_r   <= target_index_r + 1'b1;
          pause_left_r     <= pause_ticks_r;
          out_r.target_now <= 7'(tidx_ext + 32'd1);
        end else begin
          out_r.target_now <= tidx_ext[6:0];
        end
      end
      default: ;
    endcase
    if (cfg_valid && cfg_ready) pause_ticks_r <= cfg_data;
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      point_count_r  <= '0;
      target_index_r <= '0;
      pause_left_r   <= '0;
      pause_ticks_r  <= PAUSE_TICKS_RST;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    point_count_r <= CW'(WAYPOINT_DEPTH))
    else $error("waypoint count beyond table depth");
  a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
    target_index_r <= point_count_r)
    else $error("target index beyond waypoint count");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.active |-> out_item.vel_x == 32'sd0 && out_item.vel_y == 32'sd0
    && out_item.vel_z == 32'sd0 && out_item.yaw_rate == 16'sd0)
    else $error("finished command not zero");
`endif

endmodule
